// File: src/rcd_pkg.sv
// Shared types, constants and the reciprocal table of the radix converter.
package rcd_pkg;

  // Field widths
  localparam int DIG_W = 4;
  localparam int VAL_W = 20;

  // Largest number of target digits kept per request
  localparam int OUT_DIGITS = 20;
  localparam int CNT_W      = $clog2(OUT_DIGITS + 1);
  localparam int IDX_W      = $clog2(OUT_DIGITS);

  // Decimal digit positions taken from number_value
  localparam int IN_DIGITS = 6;
  localparam logic [VAL_W:0] IN_LIMIT = (VAL_W + 1)'(10 ** IN_DIGITS);

  // Base limits
  localparam logic [DIG_W-1:0] BASE_MIN = 4'd2;
  localparam logic [DIG_W-1:0] BASE_MAX = 4'd10;
  localparam logic [DIG_W-1:0] DEC_RADIX = 4'd10;

  // Division by ten: q = (x * RECIP10) >> DEC_SHIFT, exact for VAL_W-bit x
  localparam int DEC_SHIFT = 23;
  localparam logic [VAL_W-1:0] RECIP10 = VAL_W'((2 ** DEC_SHIFT + 9) / 10);

  // Division by a small base: q = (x * recip) >> RCP_SHIFT, then corrected
  localparam int RCP_SHIFT = 24;
  localparam int RCP_W     = 24;

  // Queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // One job handed from the front to the back
  typedef struct packed {
    logic             bad;
    logic [VAL_W-1:0] value;
    logic [DIG_W-1:0] base;
  } job_t;

  // Rounded-up reciprocal of a base 2..10
  function automatic logic [RCP_W-1:0] base_recip(input logic [DIG_W-1:0] b);
    logic [RCP_W-1:0] r;
    case (b)
      4'd2:    r = RCP_W'((2 ** RCP_SHIFT + 1) / 2);
      4'd3:    r = RCP_W'((2 ** RCP_SHIFT + 2) / 3);
      4'd4:    r = RCP_W'((2 ** RCP_SHIFT + 3) / 4);
      4'd5:    r = RCP_W'((2 ** RCP_SHIFT + 4) / 5);
      4'd6:    r = RCP_W'((2 ** RCP_SHIFT + 5) / 6);
      4'd7:    r = RCP_W'((2 ** RCP_SHIFT + 6) / 7);
      4'd8:    r = RCP_W'((2 ** RCP_SHIFT + 7) / 8);
      4'd9:    r = RCP_W'((2 ** RCP_SHIFT + 8) / 9);
      4'd10:   r = RCP_W'((2 ** RCP_SHIFT + 9) / 10);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: src/rcd_fifo.sv
// Two-entry job queue between the front and the back of the converter.
module rcd_fifo import rcd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   level_r, level_nxt;

  assign full    = (level_r == (PTR_W + 1)'(FIFO_DEPTH));
  assign empty   = (level_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  // pointer and level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: src/rcd_front.sv
// Front end: takes a request, checks bases and digits, evaluates the value.
module rcd_front import rcd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DIG_W-1:0] in_source_base,
  input  logic [DIG_W-1:0] in_target_base,
  input  logic [VAL_W-1:0] in_number_value,
  output logic             push,
  output job_t             push_job,
  input  logic             full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIVQ = 2'd1;
  localparam logic [1:0] F_ACC  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [DIG_W-1:0] src_r, src_nxt;
  logic [DIG_W-1:0] dst_r, dst_nxt;
  logic             bad_r, bad_nxt;
  logic [VAL_W-1:0] rest_r, rest_nxt;
  logic [VAL_W-1:0] quo_r, quo_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic [VAL_W-1:0] weight_r, weight_nxt;

  logic [2*VAL_W-1:0]     dec_prod;
  logic [VAL_W-1:0]       quo_ten;
  logic [VAL_W-1:0]       dec_diff;
  logic [DIG_W-1:0]       digit;
  logic [VAL_W+DIG_W-1:0] term;
  logic [VAL_W+DIG_W-1:0] weight_prod;
  logic                   base_bad;

  assign in_ready = (state_r == F_IDLE);
  assign push     = (state_r == F_PUSH) && !full;
  assign push_job = '{bad: bad_r, value: value_r, base: dst_r};

  // request check on the incoming fields
  assign base_bad = (in_source_base < BASE_MIN) || (in_source_base > BASE_MAX) ||
                    (in_target_base < BASE_MIN) || (in_target_base > BASE_MAX) ||
                    ({1'b0, in_number_value} >= IN_LIMIT);

  // division by ten and the digit it leaves
  assign dec_prod    = {{VAL_W{1'b0}}, rest_r} * {{VAL_W{1'b0}}, RECIP10};
  assign quo_ten     = (quo_r << 3) + (quo_r << 1);
  assign dec_diff    = rest_r - quo_ten;
  assign digit       = dec_diff[DIG_W-1:0];
  assign term        = digit * weight_r;
  assign weight_prod = weight_r * src_r;

  always_comb begin
    state_nxt  = state_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    bad_nxt    = bad_r;
    rest_nxt   = rest_r;
    quo_nxt    = quo_r;
    value_nxt  = value_r;
    weight_nxt = weight_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          src_nxt    = in_source_base;
          dst_nxt    = in_target_base;
          bad_nxt    = base_bad;
          rest_nxt   = in_number_value;
          value_nxt  = '0;
          weight_nxt = VAL_W'(1);
          state_nxt  = (base_bad || in_number_value == '0) ? F_PUSH : F_DIVQ;
        end
      end
      F_DIVQ: begin
        quo_nxt   = VAL_W'(dec_prod[2*VAL_W-1:DEC_SHIFT]);
        state_nxt = F_ACC;
      end
      F_ACC: begin
        if (digit >= src_r) begin
          bad_nxt   = 1'b1;
          state_nxt = F_PUSH;
        end else begin
          value_nxt  = value_r + term[VAL_W-1:0];
          weight_nxt = weight_prod[VAL_W-1:0];
          rest_nxt   = quo_r;
          state_nxt  = (quo_r == '0) ? F_PUSH : F_DIVQ;
        end
      end
      F_PUSH: begin
        if (!full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    bad_r    <= bad_nxt;
    rest_r   <= rest_nxt;
    quo_r    <= quo_nxt;
    value_r  <= value_nxt;
    weight_r <= weight_nxt;
  end

endmodule

// File: src/rcd_back.sv
// Back end: divides by the target base, stacks digits, emits them MSB first.
module rcd_back import rcd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             empty,
  input  job_t             pop_job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DIG_W-1:0] out_digit_value,
  output logic             out_last_digit,
  output logic             out_invalid
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_SUB  = 2'd2;
  localparam logic [1:0] B_EMIT = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [VAL_W-1:0]       val_r, val_nxt;
  logic [DIG_W-1:0]       base_r, base_nxt;
  logic                   inv_r, inv_nxt;
  logic [VAL_W+RCP_W-1:0] prod_r, prod_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [DIG_W-1:0]       stack_r [OUT_DIGITS];

  logic                   stack_we;
  logic [DIG_W-1:0]       stack_wd;
  logic [IDX_W-1:0]       stack_wa;

  logic                   out_valid_r, out_valid_nxt;
  logic [DIG_W-1:0]       out_digit_r, out_digit_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_inv_r, out_inv_nxt;
  logic                   out_free;

  logic [VAL_W-1:0]       quo;
  logic [VAL_W+DIG_W-1:0] quo_base;
  logic [VAL_W-1:0]       rem_raw;
  logic                   rem_over;
  logic [VAL_W-1:0]       quo_fix;
  logic [VAL_W-1:0]       rem_fix;

  assign out_free        = !out_valid_r || out_ready;
  assign pop             = (state_r == B_IDLE) && !empty;
  assign out_valid       = out_valid_r;
  assign out_digit_value = out_digit_r;
  assign out_last_digit  = out_last_r;
  assign out_invalid     = out_inv_r;

  // quotient estimate from the registered product, one correction step
  assign quo      = prod_r[VAL_W+RCP_W-1:RCP_SHIFT];
  assign quo_base = quo * base_r;
  assign rem_raw  = val_r - quo_base[VAL_W-1:0];
  assign rem_over = (rem_raw >= {{(VAL_W-DIG_W){1'b0}}, base_r});
  assign quo_fix  = rem_over ? quo + 1'b1 : quo;
  assign rem_fix  = rem_over ? rem_raw - {{(VAL_W-DIG_W){1'b0}}, base_r} : rem_raw;

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    base_nxt      = base_r;
    inv_nxt       = inv_r;
    prod_nxt      = prod_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    stack_we      = 1'b0;
    stack_wa      = count_r[IDX_W-1:0];
    stack_wd      = rem_fix[DIG_W-1:0];
    out_valid_nxt = out_valid_r && !out_ready;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;
    out_inv_nxt   = out_inv_r;
    case (state_r)
      B_IDLE: begin
        if (!empty) begin
          val_nxt   = pop_job.value;
          base_nxt  = pop_job.base;
          inv_nxt   = pop_job.bad;
          count_nxt = '0;
          if (pop_job.bad || pop_job.value == '0) begin
            // single zero digit, flagged when the request was rejected
            stack_we  = 1'b1;
            stack_wa  = '0;
            stack_wd  = '0;
            idx_nxt   = '0;
            state_nxt = B_EMIT;
          end else begin
            state_nxt = B_MUL;
          end
        end
      end
      B_MUL: begin
        prod_nxt  = val_r * base_recip(base_r);
        state_nxt = B_SUB;
      end
      B_SUB: begin
        stack_we  = 1'b1;
        val_nxt   = quo_fix;
        count_nxt = count_r + 1'b1;
        if (quo_fix == '0 || count_r == CNT_W'(OUT_DIGITS - 1)) begin
          idx_nxt   = count_r[IDX_W-1:0];
          state_nxt = B_EMIT;
        end else begin
          state_nxt = B_MUL;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_digit_nxt = stack_r[idx_r];
          out_last_nxt  = (idx_r == '0);
          out_inv_nxt   = inv_r;
          if (idx_r == '0) begin
            state_nxt = B_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    base_r      <= base_nxt;
    inv_r       <= inv_nxt;
    prod_r      <= prod_nxt;
    count_r     <= count_nxt;
    idx_r       <= idx_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
    out_inv_r   <= out_inv_nxt;
    if (stack_we) begin
      stack_r[stack_wa] <= stack_wd;
    end
  end

endmodule

// File: src/radix_converter_digit_stream.sv
// Flow: the front takes a request, then for each source digit up to the leading
//   nonzero one divides by ten, then checks and accumulates, then pushes into the queue;
//   the back pops it, multiplies and corrects per target digit, then sends 1 digit a cycle out
//   while out_ready is held high. The two halves overlap through the queue, so the slower one
//   sets the request rate.
// Reset: synchronous active-low rst_n empties the queue and idles both halves.
module radix_converter_digit_stream import rcd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DIG_W-1:0] in_source_base,
  input  logic [DIG_W-1:0] in_target_base,
  input  logic [VAL_W-1:0] in_number_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DIG_W-1:0] out_digit_value,
  output logic             out_last_digit,
  output logic             out_invalid
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t pop_job;

  // request check and value evaluation
  rcd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_source_base  (in_source_base),
    .in_target_base  (in_target_base),
    .in_number_value (in_number_value),
    .push            (push),
    .push_job        (push_job),
    .full            (full)
  );

  // job queue
  rcd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  // base conversion and digit emission
  rcd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .pop_job         (pop_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digit_value (out_digit_value),
    .out_last_digit  (out_last_digit),
    .out_invalid     (out_invalid)
  );

  // a rejected request gives one zero digit that closes it
  a_invalid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_last_digit && (out_digit_value == '0))
    else $error("invalid result not a single zero digit");

  // the queue is never written when full, nor read when empty
  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("job queue overrun or underrun");

  // an empty queue stays empty unless the front pushes
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    empty && !push |=> empty)
    else $error("job queue filled without a push");

endmodule

// File: tb/sv/radix_converter_digit_stream_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the radix converter: predicted digit stream checked per request.
module radix_converter_digit_stream_test;
  import rcd_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 80;
  localparam int BURST_ITEMS  = 12;
  localparam int HOLD_CYCLES  = 600;
  localparam int TAIL_CYCLES  = 200;
  localparam int REPORT_MAX   = 10;

  // One emitted target digit as the block should present it
  typedef struct packed {
    logic [DIG_W-1:0] digit;
    logic             last;
    logic             bad;
  } tdigit_t;

  // Works out the digits of each accepted request and checks them in order
  class conversion_scoreboard;
    tdigit_t pending_digits[$];
    int      mismatches;

    function int outstanding();
      return pending_digits.size();
    endfunction

    function void note_request(logic [DIG_W-1:0] src, logic [DIG_W-1:0] dst,
                               logic [VAL_W-1:0] num);
      longint unsigned  rest;
      longint unsigned  value;
      longint unsigned  weight;
      longint unsigned  d;
      logic [DIG_W-1:0] lsd_first[$];
      bit               bad;
      tdigit_t          t;
      value  = 0;
      weight = 1;
      bad    = 1'b0;
      if (src < BASE_MIN || src > BASE_MAX || dst < BASE_MIN || dst > BASE_MAX) bad = 1'b1;
      if ({1'b0, num} >= IN_LIMIT) bad = 1'b1;
      // read the decimal digits as source-base digits, least significant first
      rest = num;
      while (!bad && rest != 0) begin
        d = rest % DEC_RADIX;
        if (d >= src) begin
          bad = 1'b1;
        end else begin
          value  += d * weight;
          weight *= src;
          rest   /= DEC_RADIX;
        end
      end
      // rejected request or zero value: one closing digit 0
      if (bad || value == 0) begin
        t.digit = '0;
        t.last  = 1'b1;
        t.bad   = bad;
        pending_digits.push_back(t);
        return;
      end
      // repeated division; only the low OUT_DIGITS digits survive
      while (value != 0 && lsd_first.size() < OUT_DIGITS) begin
        lsd_first.push_back(DIG_W'(value % dst));
        value /= dst;
      end
      for (int k = lsd_first.size() - 1; k >= 0; k--) begin
        t.digit = lsd_first[k];
        t.last  = (k == 0);
        t.bad   = 1'b0;
        pending_digits.push_back(t);
      end
    endfunction

    function void report(string what, tdigit_t exp_d, tdigit_t got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s: digit/last/invalid expected %0d/%0b/%0b, got %0d/%0b/%0b",
                 $realtime, what, exp_d.digit, exp_d.last, exp_d.bad,
                 got.digit, got.last, got.bad);
    endfunction

    function void check_digit(logic [DIG_W-1:0] digit, logic last, logic bad);
      tdigit_t exp_d;
      tdigit_t got;
      got.digit = digit;
      got.last  = last;
      got.bad   = bad;
      if (pending_digits.size() == 0) begin
        exp_d = '0;
        report("digit with no request waiting", exp_d, got);
        return;
      end
      exp_d = pending_digits.pop_front();
      if (got.digit !== exp_d.digit || got.last !== exp_d.last || got.bad !== exp_d.bad)
        report("digit mismatch", exp_d, got);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [DIG_W-1:0] in_source_base = '0;
  logic [DIG_W-1:0] in_target_base = '0;
  logic [VAL_W-1:0] in_number_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [DIG_W-1:0] out_digit_value;
  logic             out_last_digit;
  logic             out_invalid;

  conversion_scoreboard scoreboard = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int phase_send[PHASES] = '{0, 86, 0, 37, 0};
  int phase_recv[PHASES] = '{0, 0, 86, 37, 0};

  radix_converter_digit_stream dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_source_base  (in_source_base),
    .in_target_base  (in_target_base),
    .in_number_value (in_number_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digit_value (out_digit_value),
    .out_last_digit  (out_last_digit),
    .out_invalid     (out_invalid)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: check accepted digits, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      scoreboard.check_digit(out_digit_value, out_last_digit, out_invalid);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request, with a random gap first, and wait for it to be taken
  task automatic send_request(input logic [DIG_W-1:0] src, input logic [DIG_W-1:0] dst,
                              input logic [VAL_W-1:0] num);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_source_base  <= src;
    in_target_base  <= dst;
    in_number_value <= num;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scoreboard.note_request(src, dst, num);
  endtask

  // Mostly well-formed digit strings; some bad digits, zeros and raw noise
  task automatic send_random();
    logic [DIG_W-1:0] src;
    logic [DIG_W-1:0] dst;
    logic [VAL_W-1:0] num;
    int unsigned      kind;
    int unsigned      ndig;
    int unsigned      badpos;
    int unsigned      scale;
    kind   = $urandom_range(99);
    src    = DIG_W'($urandom_range(BASE_MIN, BASE_MAX));
    dst    = DIG_W'($urandom_range(BASE_MIN, BASE_MAX));
    ndig   = $urandom_range(1, IN_DIGITS);
    badpos = (kind < 16 && src < BASE_MAX) ? $urandom_range(0, ndig - 1) : IN_DIGITS;
    num    = '0;
    scale  = 1;
    for (int i = 0; i < ndig; i++) begin
      if (i == badpos) num += VAL_W'($urandom_range(src, DEC_RADIX - 1) * scale);
      else             num += VAL_W'($urandom_range(0, src - 1) * scale);
      scale *= DEC_RADIX;
    end
    if (kind < 8) begin
      src = DIG_W'($urandom);
      dst = DIG_W'($urandom);
      num = VAL_W'($urandom);
    end else if (kind < 12) begin
      num = '0;
    end
    send_request(src, dst, num);
  endtask

  // Stop offering and wait for every predicted digit
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scoreboard.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: widest outputs, base limits, long numbers, bad digits, zero
    send_request(4'd10, 4'd2, 20'd999999);
    send_request(4'd10, 4'd10, 20'd999999);
    send_request(4'd2, 4'd10, 20'd111111);
    send_request(4'd2, 4'd2, 20'd0);
    send_request(4'd10, 4'd2, 20'd1);
    send_request(4'd0, 4'd10, 20'd5);
    send_request(4'd1, 4'd10, 20'd0);
    send_request(4'd11, 4'd10, 20'd5);
    send_request(4'd15, 4'd15, 20'hFFFFF);
    send_request(4'd10, 4'd0, 20'd5);
    send_request(4'd10, 4'd1, 20'd5);
    send_request(4'd10, 4'd11, 20'd5);
    send_request(4'd10, 4'd15, 20'd0);
    send_request(4'd10, 4'd10, 20'd1000000);
    send_request(4'd10, 4'd9, 20'hFFFFF);
    send_request(4'd2, 4'd10, 20'd2);
    send_request(4'd9, 4'd3, 20'd999998);
    send_request(4'd9, 4'd3, 20'd888888);
    send_request(4'd3, 4'd7, 20'd2012);
    send_request(4'd7, 4'd9, 20'd0);
    send_request(4'd5, 4'd5, 20'd43210);
    send_request(4'd6, 4'd4, 20'd5);
    send_request(4'd4, 4'd10, 20'd103);
    send_request(4'd8, 4'd2, 20'd777777);
    drain();

    // random phases with different idling on each side
    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      repeat (PHASE_ITEMS) send_random();
      drain();
      // result side held off while requests keep coming, so the block backs up
      if (p == 0) begin
        hold_left = HOLD_CYCLES;
        repeat (BURST_ITEMS) send_random();
        drain();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
